// ----- rtl/core/u8s_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_pkg
// Shared types, constants and byte-class functions for the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package u8s_pkg;

  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned HELD_DEPTH  = 3;

  localparam logic [7:0] ASCII_MAX  = 8'h7f;
  localparam logic [7:0] LEAD2_MIN  = 8'hc2;
  localparam logic [7:0] LEAD2_MAX  = 8'hdf;
  localparam logic [7:0] LEAD3_MIN  = 8'he0;
  localparam logic [7:0] LEAD3_MAX  = 8'hef;
  localparam logic [7:0] LEAD4_MIN  = 8'hf0;
  localparam logic [7:0] LEAD4_MAX  = 8'hf4;
  localparam logic [7:0] LEAD_E0    = 8'he0;
  localparam logic [7:0] LEAD_ED    = 8'hed;
  localparam logic [7:0] LEAD_F0    = 8'hf0;
  localparam logic [7:0] LEAD_F4    = 8'hf4;
  localparam logic [7:0] CONT_MIN   = 8'h80;
  localparam logic [7:0] CONT_MAX   = 8'hbf;
  localparam logic [7:0] CONT_E0_LO = 8'ha0;
  localparam logic [7:0] CONT_ED_HI = 8'h9f;
  localparam logic [7:0] CONT_F0_LO = 8'h90;
  localparam logic [7:0] CONT_F4_HI = 8'h8f;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Replacement character U+FFFD as UTF-8.
  localparam logic [7:0] REPL_SEQ [3] = '{8'hef, 8'hbf, 8'hbd};

  // Sequence length implied by a lead byte: 1 for ASCII, 0 for an invalid lead.
  localparam logic [2:0] LEN_BAD   = 3'd0;
  localparam logic [2:0] LEN_ASCII = 3'd1;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [MAX_RESULTS-1:0]      rep;
    logic [RES_CNT_W-1:0]        cnt;
  } u8s_burst_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = LEN_BAD;
    if (b <= ASCII_MAX) begin
      len = LEN_ASCII;
    end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      len = 3'd2;
    end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
      len = 3'd3;
    end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Continuation check; the range narrows on the second byte after some leads.
  function automatic logic cont_ok(input logic [7:0] lead, input logic second,
                                   input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = CONT_MIN;
    hi = CONT_MAX;
    if (second) begin
      if (lead == LEAD_E0) begin
        lo = CONT_E0_LO;
      end else if (lead == LEAD_ED) begin
        hi = CONT_ED_HI;
      end else if (lead == LEAD_F0) begin
        lo = CONT_F0_LO;
      end else if (lead == LEAD_F4) begin
        hi = CONT_F4_HI;
      end
    end
    return (b >= lo) && (b <= hi);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/u8s_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_if
// Valid/ready channels of the sanitizer: raw byte input and result output.
// ----------------------------------------------------------------------------
interface u8s_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_byte;

  modport source (output valid, output cmd, output in_byte, input ready);
  modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

interface u8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_replacement;
  logic       last_of_run;

  modport source (output valid, output out_byte, output is_replacement,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input is_replacement,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/u8s_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_decode
// Sequence state and the per-item decode into a burst of result bytes.
// ----------------------------------------------------------------------------
module u8s_decode
  import u8s_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic       cmd,
  input  wire logic [7:0] in_byte,
  output u8s_burst_t      burst
);

  logic [7:0] held       [HELD_DEPTH];
  logic [7:0] held_next  [HELD_DEPTH];
  logic [1:0] hc;
  logic [1:0] hc_next;
  logic [2:0] exp_len;
  logic [2:0] exp_len_next;

  logic       pre_r;
  logic       do_lead;
  logic       complete;
  logic [2:0] len;
  logic [2:0] base;

  always_comb begin
    held_next    = held;
    hc_next      = hc;
    exp_len_next = exp_len;
    pre_r        = 1'b0;
    do_lead      = 1'b0;
    complete     = 1'b0;
    burst        = '0;
    len          = lead_len(in_byte);

    if (cmd == CMD_FLUSH) begin
      if (hc != 2'd0) begin
        pre_r = 1'b1;
      end
    end else if (hc == 2'd0) begin
      do_lead = 1'b1;
    end else if (!cont_ok(held[0], hc == 2'd1, in_byte)) begin
      pre_r   = 1'b1;
      do_lead = 1'b1;
    end else if (({1'b0, hc} + 3'd1) >= exp_len) begin
      complete = 1'b1;
    end else begin
      held_next[hc] = in_byte;
      hc_next       = hc + 2'd1;
    end

    // Drop the held subpart on any replacement or completion.
    if (pre_r || complete) begin
      for (int i = 0; i < HELD_DEPTH; i++) begin
        held_next[i] = '0;
      end
      hc_next      = '0;
      exp_len_next = '0;
    end

    base = pre_r ? 3'd3 : 3'd0;

    if (pre_r) begin
      for (int j = 0; j < 3; j++) begin
        burst.bytes[j] = REPL_SEQ[j];
        burst.rep[j]   = 1'b1;
      end
      burst.cnt = 3'd3;
    end

    if (complete) begin
      for (int i = 0; i < HELD_DEPTH; i++) begin
        if (i < int'(hc)) begin
          burst.bytes[i] = held[i];
        end
      end
      burst.bytes[{1'b0, hc}] = in_byte;
      burst.cnt               = {1'b0, hc} + 3'd1;
    end

    if (do_lead) begin
      if (len == LEN_ASCII) begin
        burst.bytes[base] = in_byte;
        burst.cnt         = base + 3'd1;
      end else if (len == LEN_BAD) begin
        for (int j = 0; j < 3; j++) begin
          burst.bytes[base + 3'(j)] = REPL_SEQ[j];
          burst.rep[base + 3'(j)]   = 1'b1;
        end
        burst.cnt = base + 3'd3;
      end else begin
        held_next[0] = in_byte;
        hc_next      = 2'd1;
        exp_len_next = len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HELD_DEPTH; i++) begin
        held[i] <= '0;
      end
      hc      <= '0;
      exp_len <= '0;
    end else if (fire) begin
      held    <= held_next;
      hc      <= hc_next;
      exp_len <= exp_len_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/u8s_burst.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_burst
// Result register: holds one item's burst and hands it out a byte a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module u8s_burst
  import u8s_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire u8s_burst_t  burst,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_rep,
  output logic             out_last,
  output logic             can_load
);

  logic [MAX_RESULTS-1:0][7:0] bytes;
  logic [MAX_RESULTS-1:0]      rep;
  logic [RES_CNT_W-1:0]        cnt;
  logic [RES_IDX_W-1:0]        idx;

  assign out_valid = (cnt != '0);
  assign out_byte  = bytes[idx];
  assign out_rep   = rep[idx];
  assign out_last  = (idx == (cnt - 3'd1));
  assign can_load  = !out_valid || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= burst.cnt;
      idx <= '0;
    end else if (out_valid && out_ready) begin
      if (out_last) begin
        cnt <= '0;
        idx <= '0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= burst.bytes;
      rep   <= burst.rep;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/utf8_stream_sanitizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer
// Turns an arbitrary byte stream into well-formed UTF-8.
// ----------------------------------------------------------------------------
// Each input item is a data byte or a flush. ASCII bytes go straight out;
// multi-byte sequences are held until their last byte arrives and then leave
// together. A bad lead or an out-of-range continuation gives EF BF BD, drops
// the held subpart, and the offending byte starts over as a lead. A flush with
// bytes held gives one replacement. One item causes 0 to 6 result bytes, and
// last_of_run marks the final byte of each item's run. An item is decoded in
// the cycle it is accepted and its bytes leave the result register one per
// cycle while out_ch.ready is high: ASCII text runs at one item per cycle when
// the receiver does not stall, while an item that causes more than one byte
// holds input off; the next item is taken in the cycle its last byte is taken.
// ----------------------------------------------------------------------------
module utf8_stream_sanitizer
  import u8s_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  u8s_in_if.sink    in_ch,
  u8s_out_if.source out_ch
);

  u8s_burst_t burst;
  logic       can_load;
  logic       fire;

  // Take a new item whenever the result register is empty or drains now.
  assign in_ch.ready = can_load;
  assign fire        = in_ch.valid && can_load;

  u8s_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .cmd     (in_ch.cmd),
    .in_byte (in_ch.in_byte),
    .burst   (burst)
  );

  // Items that cause no result load an empty burst and leave no trace.
  u8s_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .burst     (burst),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_rep   (out_ch.is_replacement),
    .out_last  (out_ch.last_of_run),
    .can_load  (can_load)
  );

endmodule
`default_nettype wire

// ----- bench/utf8_stream_sanitizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer_tb
// Self-checking bench for the UTF-8 stream sanitizer. A queue of raw bytes
// and flushes feeds a clocked driver, and a clocked monitor takes the
// sanitized bytes. Every accepted item runs through a local model of the
// decoder, which queues the bytes the block must emit. The run goes through
// phases with different sender gaps and receiver stalls. One of them holds
// the receiver off for a long stretch.
// ----------------------------------------------------------------------------
module utf8_stream_sanitizer_tb;
  import u8s_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned ITEMS_PER_PHASE = 120;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned MAX_SHOWN       = 10;
  localparam int unsigned LIMIT_NS        = 5_000_000;

  // One raw item offered to the block: a data byte or a flush.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } raw_item_t;

  // One sanitized byte as it must leave the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_rep;
    logic       last;
  } clean_byte_t;

  // Directed opening: ASCII bounds, invalid leads, the narrowed second-byte
  // ranges after E0, ED, F0 and F4, a bad continuation that is itself a bad
  // lead (six bytes out), one that is ASCII, one that is a new lead, and
  // flushes with and without bytes held.
  localparam raw_item_t DIRECTED_ITEMS [27] = '{
    '{CMD_DATA, 8'h00}, '{CMD_DATA, 8'h7f}, '{CMD_DATA, 8'h80}, '{CMD_DATA, 8'hc1},
    '{CMD_DATA, 8'hff}, '{CMD_DATA, 8'hc2}, '{CMD_DATA, 8'h80}, '{CMD_DATA, 8'he0},
    '{CMD_DATA, 8'h9f}, '{CMD_DATA, 8'hed}, '{CMD_DATA, 8'h9f}, '{CMD_DATA, 8'hbf},
    '{CMD_DATA, 8'hf0}, '{CMD_DATA, 8'h8f}, '{CMD_DATA, 8'hf4}, '{CMD_DATA, 8'h8f},
    '{CMD_DATA, 8'hbf}, '{CMD_DATA, 8'hbf}, '{CMD_DATA, 8'hf4}, '{CMD_DATA, 8'h90},
    '{CMD_DATA, 8'he1}, '{CMD_DATA, 8'h80}, '{CMD_DATA, 8'h41}, '{CMD_DATA, 8'hdf},
    '{CMD_DATA, 8'hc2}, '{CMD_FLUSH, 8'hff}, '{CMD_FLUSH, 8'h00}
  };

  logic clk = 1'b0;
  logic rst;

  u8s_in_if  raw_ch ();
  u8s_out_if clean_ch ();

  utf8_stream_sanitizer DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (raw_ch),
    .out_ch (clean_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stimulus waiting to be offered, and the bytes the block still owes.
  raw_item_t   raw_q [$];
  clean_byte_t sanitized_q [$];
  clean_byte_t run_buf [$];
  int unsigned pushed_total = 0;
  int unsigned bad_count    = 0;

  // Phase knobs, changed only at the falling edge by the stimulus process.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        pressure_on   = 1'b0;

  // Local decoder state: the partial sequence and its full length.
  logic [7:0]  held [HELD_DEPTH];
  int unsigned held_n  = 0;
  int unsigned seq_len = 0;

  task automatic report_miss(input string msg);
    bad_count++;
    if (bad_count <= MAX_SHOWN) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic push_raw(input logic cmd, input logic [7:0] data);
    raw_item_t it;
    it.cmd  = cmd;
    it.data = data;
    raw_q = {raw_q, it};
    pushed_total++;
  endtask

  task automatic add_out(input logic [7:0] b, input logic rep);
    clean_byte_t c;
    c.out_byte = b;
    c.is_rep   = rep;
    c.last     = 1'b0;
    run_buf = {run_buf, c};
  endtask

  task automatic add_fffd();
    for (int i = 0; i < 3; i++) begin
      add_out(REPL_SEQ[i], 1'b1);
    end
  endtask

  task automatic drop_held();
    for (int i = 0; i < HELD_DEPTH; i++) begin
      held[i] = 8'h00;
    end
    held_n  = 0;
    seq_len = 0;
  endtask

  // Treat b as the first byte of a sequence; nothing is held on entry.
  task automatic open_seq(input logic [7:0] b);
    int unsigned len;
    len = 0;
    if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      len = 2;
    end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
      len = 3;
    end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      len = 4;
    end
    if (b <= ASCII_MAX) begin
      add_out(b, 1'b0);
    end else if (len == 0) begin
      add_fffd();
    end else begin
      held[0] = b;
      held_n  = 1;
      seq_len = len;
    end
  endtask

  // Work out the bytes one accepted item causes and queue them, with the
  // final one of the run marked.
  task automatic sanitize_item(input logic cmd, input logic [7:0] b);
    logic [7:0]  lo;
    logic [7:0]  hi;
    run_buf.delete();
    if (cmd == CMD_FLUSH) begin
      if (held_n != 0) begin
        add_fffd();
        drop_held();
      end
    end else if (held_n == 0) begin
      open_seq(b);
    end else begin
      lo = CONT_MIN;
      hi = CONT_MAX;
      // Narrow the range for the second byte only.
      if (held_n == 1) begin
        case (held[0])
          LEAD_E0: lo = CONT_E0_LO;
          LEAD_ED: hi = CONT_ED_HI;
          LEAD_F0: lo = CONT_F0_LO;
          LEAD_F4: hi = CONT_F4_HI;
          default: ;
        endcase
      end
      if (b < lo || b > hi) begin
        // Drop the held subpart, then start over with b as a lead.
        add_fffd();
        drop_held();
        open_seq(b);
      end else if (held_n + 1 >= seq_len) begin
        for (int i = 0; i < held_n; i++) begin
          add_out(held[i], 1'b0);
        end
        add_out(b, 1'b0);
        drop_held();
      end else begin
        held[held_n] = b;
        held_n++;
      end
    end
    if (run_buf.size() != 0) begin
      run_buf[run_buf.size() - 1].last = 1'b1;
    end
    sanitized_q = {sanitized_q, run_buf};
  endtask

  // Driver: predict on acceptance, then offer the next item or idle.
  always @(posedge clk) begin
    raw_item_t it;
    if (rst) begin
      raw_ch.valid   <= 1'b0;
      raw_ch.cmd     <= CMD_DATA;
      raw_ch.in_byte <= 8'h00;
    end else begin
      if (raw_ch.valid && raw_ch.ready) begin
        sanitize_item(raw_ch.cmd, raw_ch.in_byte);
      end
      // The offered item must hold until taken; only advance once it is.
      if (!raw_ch.valid || raw_ch.ready) begin
        if (raw_q.size() != 0 &&
            (send_idle_pct == 0 || $urandom_range(0, 99) >= send_idle_pct)) begin
          it = raw_q.pop_front();
          raw_ch.valid   <= 1'b1;
          raw_ch.cmd     <= it.cmd;
          raw_ch.in_byte <= it.data;
        end else begin
          raw_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in its own process. It runs once each
  // time pressure is switched on, while the sender keeps offering items.
  int unsigned hold_cnt;
  wire hold_active = pressure_on && (hold_cnt < HOLD_CYCLES);

  always @(posedge clk) begin
    if (rst || !pressure_on) begin
      hold_cnt <= 0;
    end else if (hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Monitor: check each taken byte against the oldest expectation, then
  // choose whether to stall the next cycle.
  always @(posedge clk) begin
    clean_byte_t got;
    clean_byte_t want;
    if (rst) begin
      clean_ch.ready <= 1'b0;
    end else begin
      if (clean_ch.valid && clean_ch.ready) begin
        got.out_byte = clean_ch.out_byte;
        got.is_rep   = clean_ch.is_replacement;
        got.last     = clean_ch.last_of_run;
        if (sanitized_q.size() == 0) begin
          report_miss($sformatf("unexpected byte %02h rep %0b last %0b",
                                got.out_byte, got.is_rep, got.last));
        end else begin
          want = sanitized_q.pop_front();
          if (got != want) begin
            report_miss($sformatf(
              "expected byte %02h rep %0b last %0b, got byte %02h rep %0b last %0b",
              want.out_byte, want.is_rep, want.last,
              got.out_byte, got.is_rep, got.last));
          end
        end
      end
      clean_ch.ready <= !hold_active &&
                        (stall_pct == 0 || $urandom_range(0, 99) >= stall_pct);
    end
  end

  // Stimulus and phase control. Everything here changes at the falling
  // edge so the clocked processes never race it.
  initial begin
    int unsigned ph;
    int unsigned target;
    int unsigned len;
    int unsigned keep;
    int unsigned r;
    logic [7:0]  seq [4];

    rst = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    for (ph = 0; ph < 4; ph++) begin
      // Phases: no idling with the long hold-off, sender gaps, receiver
      // stalls, then both at a lower rate.
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          pressure_on   = 1'b1;
          foreach (DIRECTED_ITEMS[i]) begin
            push_raw(DIRECTED_ITEMS[i].cmd, DIRECTED_ITEMS[i].data);
          end
        end
        1: begin
          send_idle_pct = 86;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 86;
        end
        default: begin
          send_idle_pct = 32;
          stall_pct     = 32;
        end
      endcase

      target = pushed_total + ITEMS_PER_PHASE;
      while (pushed_total < target) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          // Build a well-formed character with random content.
          len = $urandom_range(1, 4);
          case (len)
            1: seq[0] = 8'($urandom_range(0, ASCII_MAX));
            2: seq[0] = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
            3: seq[0] = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
            default: seq[0] = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
          endcase
          // Favor the leads with a narrowed second byte.
          if (len == 3 && $urandom_range(0, 3) == 0) begin
            seq[0] = $urandom_range(0, 1) ? LEAD_E0 : LEAD_ED;
          end else if (len == 4 && $urandom_range(0, 2) == 0) begin
            seq[0] = $urandom_range(0, 1) ? LEAD_F0 : LEAD_F4;
          end
          for (int k = 1; k < len; k++) begin
            seq[k] = 8'($urandom_range(CONT_MIN, CONT_MAX));
          end
          case (seq[0])
            LEAD_E0: seq[1] = 8'($urandom_range(CONT_E0_LO, CONT_MAX));
            LEAD_ED: seq[1] = 8'($urandom_range(CONT_MIN, CONT_ED_HI));
            LEAD_F0: seq[1] = 8'($urandom_range(CONT_F0_LO, CONT_MAX));
            LEAD_F4: seq[1] = 8'($urandom_range(CONT_MIN, CONT_F4_HI));
            default: ;
          endcase
          keep = len;
          // Break one in eight: cut it short or corrupt a trailing byte.
          if (r >= 70 && len > 1) begin
            if ($urandom_range(0, 1)) begin
              keep = $urandom_range(1, len - 1);
            end else begin
              seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
            end
          end
          for (int k = 0; k < keep; k++) begin
            push_raw(CMD_DATA, seq[k]);
          end
        end else if (r < 92) begin
          push_raw(CMD_DATA, 8'($urandom_range(0, 255)));
        end else if (r < 96) begin
          push_raw(CMD_DATA, 8'($urandom_range(CONT_MIN, CONT_MAX)));
        end else begin
          push_raw(CMD_FLUSH, 8'($urandom_range(0, 255)));
        end
      end

      // Hold the sender until every queued item is taken and every byte
      // owed has come out.
      while (raw_q.size() != 0 || raw_ch.valid) @(negedge clk);
      while (sanitized_q.size() != 0) @(negedge clk);
      pressure_on = 1'b0;
    end

    // Keep the receiver open a while to catch any stray bytes.
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (bad_count == 0) begin
      $display("utf8_stream_sanitizer: match");
    end else begin
      $display("utf8_stream_sanitizer: mismatch");
    end
    $finish;
  end

  // Watchdog: a stuck handshake or a missing byte ends up here.
  initial begin
    #(LIMIT_NS);
    $display("utf8_stream_sanitizer: mismatch");
    $finish;
  end

endmodule

// ----- utf8_stream_sanitizer.f -----
rtl/core/u8s_pkg.sv
rtl/core/u8s_if.sv
rtl/core/u8s_decode.sv
rtl/core/u8s_burst.sv
rtl/core/utf8_stream_sanitizer.sv
bench/utf8_stream_sanitizer_tb.sv
